// File: design/wsf_pkg.sv
// ----------------------------------------------------------------------------
// wsf_pkg
// Shared types and constants of the wrapping substring finder: register
// codes, field widths and the bundles passed between the top level and
// the window compare.
// ----------------------------------------------------------------------------
package wsf_pkg;

   localparam int MAX_NEEDLE_DEF  = 16;
   localparam int OFFSET_BITS_DEF = 40;

   localparam int DATA_W       = 8;
   localparam int NEEDLE_BYTES = 16;
   localparam int LENGTH_W     = 5;
   localparam int LEN_W        = 7;
   localparam int WORD_W       = 64;
   localparam int START_W      = 40;
   localparam int INDEX_W      = 3;

   typedef enum logic [INDEX_W-1:0] {
      CSR_NEEDLE_LENGTH   = 3'd0,
      CSR_NEEDLE_BYTES_LO = 3'd1,
      CSR_NEEDLE_BYTES_HI = 3'd2,
      CSR_CASE_SENSITIVE  = 3'd3,
      CSR_SEARCH_BACKWARD = 3'd4,
      CSR_START_OFFSET    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [NEEDLE_BYTES*DATA_W-1:0] needle;
      logic [LENGTH_W-1:0]            length;
      logic                           case_sensitive;
   } needle_cfg_type;

   typedef struct packed {
      logic             hit;
      logic [LEN_W-1:0] span;
   } match_status_type;

endpackage

// File: design/wrapping_substring_finder.sv
// the beat with the last byte is taken into the input beat register, then sets the result beat register
// throughput: one byte beat per cycle unless a last byte stalls, set by the single window compare per byte
// the only stall is a last byte held while the previous result beat is not taken
// reset clears configuration, valid flags, byte position, window and match state; no clearing pass
// ----------------------------------------------------------------------------
// wrapping_substring_finder
// Streams file bytes, tracks needle matches before and after the start
// offset and returns one result beat at the end of each file.
// ----------------------------------------------------------------------------
module wrapping_substring_finder #(
   parameter int MaxNeedle  = wsf_pkg::MAX_NEEDLE_DEF,
   parameter int OffsetBits = wsf_pkg::OFFSET_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [wsf_pkg::INDEX_W-1:0]   csr_index,
   input  logic [wsf_pkg::WORD_W-1:0]    csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [wsf_pkg::DATA_W-1:0]    req_data_byte,
   input  logic                          req_last_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_match_found,
   output logic [wsf_pkg::START_W-1:0]   rsp_match_offset,
   output logic                          rsp_wrapped
);
   import wsf_pkg::*;

   // configuration
   logic [LENGTH_W-1:0] needle_length_ff;
   logic [WORD_W-1:0]   needle_lo_ff;
   logic [WORD_W-1:0]   needle_hi_ff;
   logic                case_sensitive_ff;
   logic                search_backward_ff;
   logic [START_W-1:0]  start_offset_ff;

   // input stage
   logic              in_valid_ff;
   logic [DATA_W-1:0] in_data_ff;
   logic              in_last_ff;
   logic              go;

   // match tracking
   logic [OffsetBits-1:0] pos_ff;
   logic [OffsetBits-1:0] first_before_ff, first_before_in;
   logic [OffsetBits-1:0] last_before_ff, last_before_in;
   logic [OffsetBits-1:0] first_after_ff, first_after_in;
   logic [OffsetBits-1:0] last_after_ff, last_after_in;
   logic [1:0]            seen_ff, seen_in;

   logic [OffsetBits-1:0] start_pos;
   logic [OffsetBits-1:0] match_start;
   logic [OffsetBits:0]   match_end;
   logic                  before_hit;
   logic                  after_hit;

   // result
   logic                rsp_valid_ff;
   logic                found_in;
   logic [START_W-1:0]  offset_in;
   logic                wrapped_in;
   logic                found_ff;
   logic [START_W-1:0]  offset_ff;
   logic                wrapped_ff;

   needle_cfg_type   cfg;
   match_status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_length_ff   <= '0;
         needle_lo_ff       <= '0;
         needle_hi_ff       <= '0;
         case_sensitive_ff  <= 1'b0;
         search_backward_ff <= 1'b0;
         start_offset_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_NEEDLE_LENGTH:   needle_length_ff   <= csr_wdata[LENGTH_W-1:0];
            CSR_NEEDLE_BYTES_LO: needle_lo_ff       <= csr_wdata;
            CSR_NEEDLE_BYTES_HI: needle_hi_ff       <= csr_wdata;
            CSR_CASE_SENSITIVE:  case_sensitive_ff  <= csr_wdata[0];
            CSR_SEARCH_BACKWARD: search_backward_ff <= csr_wdata[0];
            CSR_START_OFFSET:    start_offset_ff    <= csr_wdata[START_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.needle         = {needle_hi_ff, needle_lo_ff};
   assign cfg.length         = needle_length_ff;
   assign cfg.case_sensitive = case_sensitive_ff;

   // input beat register
   assign go        = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   wsf_window_match #(
      .MaxNeedle (MaxNeedle)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .last   (in_last_ff),
      .data   (in_data_ff),
      .cfg    (cfg),
      .status (status)
   );

   always_comb begin
      start_pos   = OffsetBits'(start_offset_ff);
      match_start = pos_ff - OffsetBits'(status.span);
      match_end   = {1'b0, pos_ff} + (OffsetBits+1)'(1);
      before_hit  = status.hit && (match_end <= {1'b0, start_pos});
      after_hit   = status.hit && !(match_end <= {1'b0, start_pos})
                    && (match_start >= start_pos);

      first_before_in = (before_hit && !seen_ff[0]) ? match_start : first_before_ff;
      last_before_in  = before_hit ? match_start : last_before_ff;
      first_after_in  = (after_hit && !seen_ff[1]) ? match_start : first_after_ff;
      last_after_in   = after_hit ? match_start : last_after_ff;
      seen_in         = seen_ff | {after_hit, before_hit};

      found_in   = 1'b0;
      offset_in  = '0;
      wrapped_in = 1'b0;
      if (!search_backward_ff) begin
         if (seen_in[1]) begin
            found_in  = 1'b1;
            offset_in = START_W'(first_after_in);
         end else if (seen_in[0]) begin
            found_in   = 1'b1;
            offset_in  = START_W'(first_before_in);
            wrapped_in = 1'b1;
         end
      end else begin
         if (seen_in[0]) begin
            found_in  = 1'b1;
            offset_in = START_W'(last_before_in);
         end else if (seen_in[1]) begin
            found_in   = 1'b1;
            offset_in  = START_W'(last_after_in);
            wrapped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (go && in_last_ff)) begin
         pos_ff          <= '0;
         first_before_ff <= '0;
         last_before_ff  <= '0;
         first_after_ff  <= '0;
         last_after_ff   <= '0;
         seen_ff         <= '0;
      end else if (go) begin
         pos_ff          <= pos_ff + OffsetBits'(1);
         first_before_ff <= first_before_in;
         last_before_ff  <= last_before_in;
         first_after_ff  <= first_after_in;
         last_after_ff   <= last_after_in;
         seen_ff         <= seen_in;
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (go && in_last_ff) begin
         found_ff   <= found_in;
         offset_ff  <= offset_in;
         wrapped_ff <= wrapped_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match_found  = found_ff;
   assign rsp_match_offset = offset_ff;
   assign rsp_wrapped      = wrapped_ff;

endmodule

// File: design/wsf_window_match.sv
// ----------------------------------------------------------------------------
// wsf_window_match
// Holds the recent file bytes and compares the window that ends at the
// current byte against the needle, one comparator lane per needle byte.
// ----------------------------------------------------------------------------
module wsf_window_match #(
   parameter int MaxNeedle = wsf_pkg::MAX_NEEDLE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic                          last,
   input  logic [wsf_pkg::DATA_W-1:0]    data,
   input  wsf_pkg::needle_cfg_type       cfg,
   output wsf_pkg::match_status_type     status
);
   import wsf_pkg::*;

   localparam int HistDepth = (MaxNeedle > 1) ? MaxNeedle - 1 : 1;

   logic [DATA_W-1:0] hist_ff [HistDepth];
   logic [DATA_W-1:0] hist_in [HistDepth];
   logic [LEN_W-1:0]  fill_ff;
   logic [LEN_W-1:0]  fill_in;

   logic [DATA_W-1:0] win [MaxNeedle];
   logic [DATA_W-1:0] needle_b [NEEDLE_BYTES];
   logic [DATA_W-1:0] lane_nb [MaxNeedle];
   logic [LEN_W-1:0]  lane_idx [MaxNeedle];
   logic [MaxNeedle-1:0] lane_ok;
   logic [LEN_W-1:0]  len;
   logic [LEN_W-1:0]  span;

   function automatic logic [DATA_W-1:0] fold(input logic [DATA_W-1:0] b,
                                              input logic exact);
      if (!exact && b >= 8'h41 && b <= 8'h5a) begin
         return b + 8'h20;
      end
      return b;
   endfunction

   always_comb begin
      if ({2'b00, cfg.length} > LEN_W'(MaxNeedle)) begin
         len = LEN_W'(MaxNeedle);
      end else begin
         len = {2'b00, cfg.length};
      end
      span = len - LEN_W'(1);
   end

   always_comb begin
      for (int n = 0; n < NEEDLE_BYTES; n++) begin
         needle_b[n] = cfg.needle[n*DATA_W +: DATA_W];
      end
      win[0] = data;
      for (int k = 1; k < MaxNeedle; k++) begin
         win[k] = hist_ff[k-1];
      end
      for (int k = 0; k < MaxNeedle; k++) begin
         lane_idx[k] = span - LEN_W'(k);
         if (lane_idx[k] < LEN_W'(NEEDLE_BYTES)) begin
            lane_nb[k] = needle_b[lane_idx[k][3:0]];
         end else begin
            lane_nb[k] = '0;
         end
         if (LEN_W'(k) < len) begin
            lane_ok[k] = fold(win[k], cfg.case_sensitive)
                         == fold(lane_nb[k], cfg.case_sensitive);
         end else begin
            lane_ok[k] = 1'b1;
         end
      end
   end

   assign status.hit  = (len != '0) && (fill_ff >= span) && (&lane_ok);
   assign status.span = span;

   // window shift, cleared at end of file
   always_comb begin
      hist_in[0] = data;
      for (int k = 1; k < HistDepth; k++) begin
         hist_in[k] = hist_ff[k-1];
      end
      if (fill_ff < LEN_W'(MaxNeedle - 1)) begin
         fill_in = fill_ff + LEN_W'(1);
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (go && last)) begin
         fill_ff <= '0;
         for (int k = 0; k < HistDepth; k++) begin
            hist_ff[k] <= '0;
         end
      end else if (go) begin
         fill_ff <= fill_in;
         for (int k = 0; k < HistDepth; k++) begin
            hist_ff[k] <= hist_in[k];
         end
      end
   end

endmodule

// File: test/wrapping_substring_finder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wrapping_substring_finder_tb
// Streams files through the finder under a range of needle, case, direction
// and start settings. End-of-file results are predicted by a search kept in
// this bench and checked in order against every result beat.
// ----------------------------------------------------------------------------
module wrapping_substring_finder_tb;
   import wsf_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 450;
   localparam logic [INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [INDEX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [DATA_W-1:0] UPPER_A  = 8'h41;
   localparam logic [DATA_W-1:0] UPPER_Z  = 8'h5A;
   localparam logic [DATA_W-1:0] LOWER_A  = 8'h61;
   localparam logic [DATA_W-1:0] LOWER_Z  = 8'h7A;
   localparam logic [DATA_W-1:0] CASE_BIT = 8'h20;
   localparam logic [DATA_W-1:0] BACKTICK = 8'h60;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              last;
   } file_beat_type;

   typedef struct packed {
      logic               found;
      logic [START_W-1:0] offset;
      logic               wrapped;
   } search_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [INDEX_W-1:0]   csr_index = '0;
   logic [WORD_W-1:0]    csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [DATA_W-1:0]    req_data_byte = '0;
   logic                 req_last_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_match_found;
   logic [START_W-1:0]   rsp_match_offset;
   logic                 rsp_wrapped;

   // settings as the block holds them
   logic [LENGTH_W-1:0]  cfg_length = '0;
   logic [WORD_W-1:0]    cfg_lo = '0;
   logic [WORD_W-1:0]    cfg_hi = '0;
   logic                 cfg_exact = 1'b0;
   logic                 cfg_backward = 1'b0;
   logic [START_W-1:0]   cfg_start = '0;

   // per-file search state
   logic [DATA_W-1:0]    history [NEEDLE_BYTES];
   logic [START_W-1:0]   position;
   logic [START_W-1:0]   first_before, last_before, first_after, last_after;
   logic                 seen_before, seen_after;
   int                   filled;

   file_beat_type        byte_stream[$];
   search_result_type    predicted_results[$];
   file_beat_type        next_beat;
   search_result_type    want;
   logic                 steady = 1'b0;
   int                   error_count = 0;
   int                   cycle_count = 0;

   wrapping_substring_finder dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_match_found  (rsp_match_found),
      .rsp_match_offset (rsp_match_offset),
      .rsp_wrapped      (rsp_wrapped)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void clear_file_state();
      foreach (history[i]) history[i] = '0;
      position     = '0;
      first_before = '0;
      last_before  = '0;
      first_after  = '0;
      last_after   = '0;
      seen_before  = 1'b0;
      seen_after   = 1'b0;
      filled       = 0;
   endfunction

   function automatic int effective_span();
      return (cfg_length > NEEDLE_BYTES) ? NEEDLE_BYTES : int'(cfg_length);
   endfunction

   function automatic logic [DATA_W-1:0] needle_byte(input int i);
      if (i < 8) return cfg_lo[8*i +: 8];
      if (i < NEEDLE_BYTES) return cfg_hi[8*(i-8) +: 8];
      return '0;
   endfunction

   function automatic logic [DATA_W-1:0] fold_case(input logic [DATA_W-1:0] b);
      if (!cfg_exact && b >= UPPER_A && b <= UPPER_Z) return b | CASE_BIT;
      return b;
   endfunction

   function automatic logic [DATA_W-1:0] pick_text_byte();
      unique case ($urandom_range(0, 13))
         0, 1:    return "a";
         2, 3:    return "b";
         4, 5:    return "A";
         6, 7:    return "B";
         8:       return "@";
         9:       return "[";
         10:      return BACKTICK;
         11:      return "{";
         12:      return "Z";
         default: return "z";
      endcase
   endfunction

   function automatic void advance_search(input logic [DATA_W-1:0] cur, input logic last);
      int                 span;
      int                 i;
      logic               hit;
      logic [DATA_W-1:0]  b;
      logic [START_W-1:0] s;
      logic [START_W:0]   e;
      search_result_type  r;
      span = effective_span();
      if (span > 0 && filled >= span - 1) begin
         hit = 1'b1;
         for (i = 0; i < span; i++) begin
            if (i == span - 1) begin
               b = cur;
            end else begin
               b = history[span-2-i];
            end
            if (fold_case(b) != fold_case(needle_byte(i))) hit = 1'b0;
         end
         if (hit) begin
            s = position - START_W'(span - 1);
            e = {1'b0, position} + 1'b1;
            if (e <= {1'b0, cfg_start}) begin
               if (!seen_before) first_before = s;
               last_before = s;
               seen_before = 1'b1;
            end else if (s >= cfg_start) begin
               if (!seen_after) first_after = s;
               last_after = s;
               seen_after = 1'b1;
            end
         end
      end
      for (i = NEEDLE_BYTES - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = cur;
      if (filled < NEEDLE_BYTES) filled++;
      position = position + 1'b1;
      if (last) begin
         r = '0;
         if (!cfg_backward) begin
            if (seen_after) begin
               r.found  = 1'b1;
               r.offset = first_after;
            end else if (seen_before) begin
               r.found   = 1'b1;
               r.offset  = first_before;
               r.wrapped = 1'b1;
            end
         end else begin
            if (seen_before) begin
               r.found  = 1'b1;
               r.offset = last_before;
            end else if (seen_after) begin
               r.found   = 1'b1;
               r.offset  = last_after;
               r.wrapped = 1'b1;
            end
         end
         predicted_results = {predicted_results, r};
         clear_file_state();
      end
   endfunction

   task automatic flag_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   task automatic write_register(input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      unique case (idx)
         CSR_NEEDLE_LENGTH:   cfg_length   = value[LENGTH_W-1:0];
         CSR_NEEDLE_BYTES_LO: cfg_lo       = value;
         CSR_NEEDLE_BYTES_HI: cfg_hi       = value;
         CSR_CASE_SENSITIVE:  cfg_exact    = value[0];
         CSR_SEARCH_BACKWARD: cfg_backward = value[0];
         CSR_START_OFFSET:    cfg_start    = value[START_W-1:0];
         default: ;
      endcase
   endtask

   function automatic void queue_file(input logic [DATA_W-1:0] bytes[$]);
      file_beat_type beat;
      for (int i = 0; i < bytes.size(); i++) begin
         beat.data = bytes[i];
         beat.last = (i == bytes.size() - 1);
         byte_stream = {byte_stream, beat};
      end
   endfunction

   function automatic void text_file(input string txt);
      logic [DATA_W-1:0] bytes[$];
      for (int i = 0; i < txt.len(); i++) bytes = {bytes, txt[i]};
      queue_file(bytes);
   endfunction

   task automatic wait_until_idle();
      do @(negedge clock);
      while (byte_stream.size() != 0 || req_valid || predicted_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("wrapping_substring_finder_tb failed");
         $finish;
      end
   end

   // byte beat driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            advance_search(req_data_byte, req_last_byte);
         end
         if (!req_valid || req_ready) begin
            if (byte_stream.size() != 0 && (steady || $urandom_range(0, 99) >= 14)) begin
               next_beat = byte_stream.pop_front();
               req_valid     <= 1'b1;
               req_data_byte <= next_beat.data;
               req_last_byte <= next_beat.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result beat monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               flag_mismatch($sformatf("unexpected result found=%0b offset=%0d wrapped=%0b",
                                       rsp_match_found, rsp_match_offset, rsp_wrapped));
            end else begin
               want = predicted_results.pop_front();
               if (rsp_match_found !== want.found)
                  flag_mismatch($sformatf("match_found %0b, want %0b",
                                          rsp_match_found, want.found));
               if (rsp_match_offset !== want.offset)
                  flag_mismatch($sformatf("match_offset %0d, want %0d",
                                          rsp_match_offset, want.offset));
               if (rsp_wrapped !== want.wrapped)
                  flag_mismatch($sformatf("wrapped %0b, want %0b", rsp_wrapped, want.wrapped));
            end
         end
         rsp_ready <= steady || $urandom_range(0, 99) >= 14;
      end
   end

   initial begin
      int                phase;
      int                sent_bytes;
      int                span;
      int                n;
      int                spot;
      int                i;
      int                k;
      int                choice;
      logic              noisy;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] bytes[$];
      logic [WORD_W-1:0] word;

      clear_file_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty needle straight out of reset
      queue_file('{8'h00, 8'hFF});
      wait_until_idle();

      write_register(CSR_NEEDLE_LENGTH, 64'd3);
      write_register(CSR_NEEDLE_BYTES_LO, 64'h1122_3344_5563_6261);
      write_register(CSR_NEEDLE_BYTES_HI, '1);
      write_register(CSR_CASE_SENSITIVE, 64'd0);
      write_register(CSR_SEARCH_BACKWARD, 64'd0);
      write_register(CSR_START_OFFSET, 64'd4);
      write_register(CSR_SPARE_LO, '1);
      write_register(CSR_SPARE_HI, '0);
      // folded match before start, one straddling start
      text_file("ABCabc");
      text_file("xyzwabc");
      wait_until_idle();

      // exact compare, backward, start past the end of file
      write_register(CSR_SEARCH_BACKWARD, 64'd1);
      write_register(CSR_CASE_SENSITIVE, 64'd1);
      write_register(CSR_START_OFFSET, '1);
      text_file("abcABCabc");
      wait_until_idle();

      // oversized length, window never fills
      write_register(CSR_NEEDLE_LENGTH, '1);
      write_register(CSR_NEEDLE_BYTES_LO, '1);
      write_register(CSR_START_OFFSET, '0);
      write_register(CSR_SEARCH_BACKWARD, 64'd0);
      queue_file('{8'hFF});
      wait_until_idle();

      phase = 0;
      sent_bytes = 0;
      while (sent_bytes < RANDOM_BYTES) begin
         steady = (phase == 2);

         word = {$urandom, $urandom};
         choice = $urandom_range(0, 99);
         if (choice < 5) word[LENGTH_W-1:0] = '0;
         else if (choice < 15) word[LENGTH_W-1:0] = LENGTH_W'(NEEDLE_BYTES);
         else if (choice < 22) word[LENGTH_W-1:0] = LENGTH_W'($urandom_range(17, 31));
         else word[LENGTH_W-1:0] = LENGTH_W'($urandom_range(1, 6));
         write_register(CSR_NEEDLE_LENGTH, word);
         for (i = 0; i < 2; i++) begin
            if ($urandom_range(0, 9) < 3) begin
               word = {$urandom, $urandom};
            end else begin
               for (k = 0; k < 8; k++) word[8*k +: 8] = pick_text_byte();
            end
            write_register(i == 0 ? CSR_NEEDLE_BYTES_LO : CSR_NEEDLE_BYTES_HI, word);
         end
         write_register(CSR_CASE_SENSITIVE, {$urandom, $urandom});
         write_register(CSR_SEARCH_BACKWARD, {$urandom, $urandom});
         word = {$urandom, $urandom};
         choice = $urandom_range(0, 99);
         if (choice < 20) word[START_W-1:0] = '0;
         else if (choice < 30) word[START_W-1:0] = '1;
         else if (choice >= 40) word[START_W-1:0] = START_W'($urandom_range(0, 24));
         write_register(CSR_START_OFFSET, word);
         if ($urandom_range(0, 3) == 0)
            write_register($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI,
                           {$urandom, $urandom});

         span = effective_span();
         repeat ($urandom_range(2, 5)) begin
            bytes = {};
            n = (span >= 10) ? $urandom_range(1, 40) : $urandom_range(1, 16);
            noisy = ($urandom_range(0, 9) == 0);
            for (i = 0; i < n; i++)
               bytes = {bytes, (noisy ? DATA_W'($urandom) : pick_text_byte())};
            // plant copies of the needle, case shuffled when folding
            if (span > 0 && n >= span && !noisy) begin
               repeat ($urandom_range(0, 2)) begin
                  spot = $urandom_range(0, n - span);
                  for (i = 0; i < span; i++) begin
                     b = needle_byte(i);
                     if (!cfg_exact && $urandom_range(0, 1) &&
                         ((b >= UPPER_A && b <= UPPER_Z) || (b >= LOWER_A && b <= LOWER_Z)))
                        b = b ^ CASE_BIT;
                     bytes[spot + i] = b;
                  end
               end
            end
            sent_bytes += n;
            queue_file(bytes);
         end
         wait_until_idle();
         phase++;
      end
      steady = 1'b0;

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("wrapping_substring_finder_tb passed");
      end else begin
         $display("wrapping_substring_finder_tb failed");
      end
      $finish;
   end

endmodule

// File: wrapping_substring_finder.f
design/wsf_pkg.sv
design/wsf_window_match.sv
design/wrapping_substring_finder.sv
test/wrapping_substring_finder_tb.sv
